[rtl/mwo_pkg.sv]
// Package for the mecanum wheel odometry block: widths, register indexes,
// reset values, sequencer state type. No dependencies.
package mwo_pkg;

   localparam int LAG    = 4;
   localparam int PTR_W  = (LAG > 1) ? $clog2(LAG) : 1;
   localparam int FILL_W = $clog2(LAG + 1);

   localparam int NUM_WHEELS = 4;
   localparam int TIME_W     = 32;
   localparam int POS_W      = 32;
   localparam int GAIN_W     = 24;
   localparam int VEL_W      = 32;
   localparam int DIFF_W     = POS_W + 1;
   localparam int SUM_W      = DIFF_W + 2;
   localparam int MAG_W      = SUM_W;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int P1_W       = MAG_W + GAIN_W;
   localparam int ACC_W      = P1_W + TIME_W;
   localparam int DIV_W      = TIME_W + 8;
   localparam int DCNT_W     = 4;

   localparam int REQ_W      = TIME_W + NUM_WHEELS * POS_W;
   localparam int RSP_W      = 3 * VEL_W + TIME_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_LINEAR_GAIN  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGULAR_GAIN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_UNITS   = 2'd2;

   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 24'd8784;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 24'd23802;
   localparam logic [TIME_W-1:0] TIME_UNITS_RST   = 32'd1000000;

   localparam logic [1:0] COMP_VX = 2'd0;
   localparam logic [1:0] COMP_VY = 2'd1;
   localparam logic [1:0] COMP_WZ = 2'd2;

   localparam logic [2:0] MSTEP_LAST = 3'd5;
   localparam logic [DCNT_W-1:0] DCNT_LAST = 4'd15;

   localparam logic [VEL_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [VEL_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SUM  = 8'b0000_0010,
      S_ABS  = 8'b0000_0100,
      S_MUL  = 8'b0000_1000,
      S_SAT  = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_FIN  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

endpackage

[rtl/mecanum_wheel_odometry_top.sv]
// Mecanum wheel odometry: sample history, tick sums, shared multiplier and
// two-bit-per-cycle divider under one sequencer. Depends on mwo_pkg.
//
// Usage:
//  req_*  : one word per encoder sample (timestamp and four wheel counts).
//  rsp_*  : one word per sample once LAG earlier samples are held; carries
//           vx, vy, yaw rate in Q16.16 and the sample time. tuser flags a zero
//           elapsed time, in which case the velocities are zero.
//  csr_*  : register writes (linear gain, angular gain, time units per second),
//           taken on csr_we high; the user writes only while idle (not enforced).
//  Sequence: a sample that only fills the history leaves the sequencer idle.
//  A sample with a zero interval goes from idle straight to the done state,
//  which loads the output register. Otherwise each of the three components
//  runs sum, magnitude, six multiplier steps on the one 32x32 multiplier, a
//  saturation check, the divider (skipped when the quotient saturates) and a
//  final step. One item at a time; req_tready is high only when idle.
//  Reset clears the sequencer, the history fill count and the output valid,
//  and loads the register reset values.
//  A stalled receiver holds the result in the output register; the next
//  sample is still taken, and its result waits until that register frees.
module mecanum_wheel_odometry_top
   import mwo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample_time, wheel_position_0, 1, 2, 3
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // velocity_x, velocity_y, yaw_rate, result_time
   output logic [RSP_W-1:0]      rsp_tdata,
   // zero_interval
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [GAIN_W-1:0] lin_gain_ff, lin_gain_in;
   logic [GAIN_W-1:0] ang_gain_ff, ang_gain_in;
   logic [TIME_W-1:0] tups_ff, tups_in;

   logic [TIME_W-1:0] th_ff [LAG];
   logic [TIME_W-1:0] th_in [LAG];
   logic [POS_W-1:0]  ph_ff [LAG][NUM_WHEELS];
   logic [POS_W-1:0]  ph_in [LAG][NUM_WHEELS];
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic signed [DIFF_W-1:0] d_ff [NUM_WHEELS];
   logic signed [DIFF_W-1:0] d_in [NUM_WHEELS];
   logic [TIME_W-1:0] dt_ff, dt_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              zero_ff, zero_in;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [1:0]        cidx_ff, cidx_in;
   logic [2:0]        mstep_ff, mstep_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [P1_W-1:0]   p1_ff, p1_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              sat_ff, sat_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [VEL_W-1:0]  dvd_ff, dvd_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [VEL_W-1:0]  res_ff [3];
   logic [VEL_W-1:0]  res_in [3];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   logic              req_acc;
   logic [TIME_W-1:0] now_w;
   logic [POS_W-1:0]  wpos [NUM_WHEELS];
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [GAIN_W-1:0] gain_sel;
   logic [DIV_W-1:0]  divisor;
   logic [DIV_W:0]    r1, r1s, r2, r2s;
   logic              b1, b2;
   logic [VEL_W-1:0]  limit, qv;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign now_w      = req_tdata[TIME_W-1:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      for (int j = 0; j < NUM_WHEELS; j++) begin
         wpos[j] = req_tdata[TIME_W + POS_W*j +: POS_W];
      end
   end

   assign gain_sel = (cidx_ff == COMP_WZ) ? ang_gain_ff : lin_gain_ff;
   assign divisor  = {dt_ff, 8'd0};

   // shared multiplier operand select
   always_comb begin
      case (mstep_ff)
         3'd0: begin
            mul_a = mag_ff[MUL_W-1:0];
            mul_b = MUL_W'(gain_sel);
         end
         3'd1: begin
            mul_a = MUL_W'(mag_ff[MAG_W-1:MUL_W]);
            mul_b = MUL_W'(gain_sel);
         end
         3'd3: begin
            mul_a = p1_ff[MUL_W-1:0];
            mul_b = tups_ff;
         end
         3'd4: begin
            mul_a = MUL_W'(p1_ff[P1_W-1:MUL_W]);
            mul_b = tups_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // two restoring division steps per cycle
   always_comb begin
      r1  = {rem_ff, dvd_ff[VEL_W-1]};
      b1  = (r1 >= {1'b0, divisor});
      r1s = b1 ? (r1 - {1'b0, divisor}) : r1;
      r2  = {r1s[DIV_W-1:0], dvd_ff[VEL_W-2]};
      b2  = (r2 >= {1'b0, divisor});
      r2s = b2 ? (r2 - {1'b0, divisor}) : r2;
   end

   assign limit = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign qv    = (sat_ff || (dvd_ff > limit)) ? limit : dvd_ff;

   always_comb begin
      state_in     = state_ff;
      lin_gain_in  = lin_gain_ff;
      ang_gain_in  = ang_gain_ff;
      tups_in      = tups_ff;
      th_in        = th_ff;
      ph_in        = ph_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      d_in         = d_ff;
      dt_in        = dt_ff;
      now_in       = now_ff;
      zero_in      = zero_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cidx_in      = cidx_ff;
      mstep_in     = mstep_ff;
      prod_in      = prod_ff;
      p1_in        = p1_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      dcnt_in      = dcnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_LINEAR_GAIN:  lin_gain_in = csr_wdata[GAIN_W-1:0];
            CSR_ANGULAR_GAIN: ang_gain_in = csr_wdata[GAIN_W-1:0];
            CSR_TIME_UNITS:   tups_in     = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (fill_ff < FILL_W'(LAG)) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  dt_in  = now_w - th_ff[ptr_ff];
                  now_in = now_w;
                  for (int j = 0; j < NUM_WHEELS; j++) begin
                     d_in[j] = DIFF_W'($signed(wpos[j])) - DIFF_W'($signed(ph_ff[ptr_ff][j]));
                  end
                  cidx_in = COMP_VX;
                  if (dt_in == '0) begin
                     zero_in  = 1'b1;
                     res_in   = '{default: '0};
                     state_in = S_DONE;
                  end else begin
                     zero_in  = 1'b0;
                     state_in = S_SUM;
                  end
               end
               th_in[ptr_ff] = now_w;
               for (int j = 0; j < NUM_WHEELS; j++) begin
                  ph_in[ptr_ff][j] = wpos[j];
               end
               ptr_in = (ptr_ff == PTR_W'(LAG - 1)) ? '0 : ptr_ff + 1'b1;
            end
         end
         S_SUM: begin
            case (cidx_ff)
               COMP_VX: sum_in = SUM_W'(d_ff[0]) + SUM_W'(d_ff[1])
                               + SUM_W'(d_ff[2]) + SUM_W'(d_ff[3]);
               COMP_VY: sum_in = SUM_W'(d_ff[1]) - SUM_W'(d_ff[0])
                               + SUM_W'(d_ff[2]) - SUM_W'(d_ff[3]);
               COMP_WZ: sum_in = SUM_W'(d_ff[1]) - SUM_W'(d_ff[0])
                               - SUM_W'(d_ff[2]) + SUM_W'(d_ff[3]);
               default: sum_in = '0;
            endcase
            state_in = S_ABS;
         end
         S_ABS: begin
            neg_in   = sum_ff[SUM_W-1];
            mag_in   = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
            mstep_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = mul_p;
            case (mstep_ff)
               3'd1: p1_in = P1_W'(prod_ff);
               3'd2: p1_in = p1_ff + {prod_ff[P1_W-MUL_W-1:0], {MUL_W{1'b0}}};
               3'd4: acc_in = ACC_W'(prod_ff);
               3'd5: acc_in = acc_ff + {prod_ff[P1_W-1:0], {MUL_W{1'b0}}};
               default: ;
            endcase
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == MSTEP_LAST) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            sat_in  = (acc_ff[ACC_W-1:VEL_W] >= (ACC_W-VEL_W)'(divisor));
            rem_in  = acc_ff[VEL_W +: DIV_W];
            dvd_in  = acc_ff[VEL_W-1:0];
            dcnt_in = '0;
            state_in = sat_in ? S_FIN : S_DIV;
         end
         S_DIV: begin
            rem_in  = r2s[DIV_W-1:0];
            dvd_in  = {dvd_ff[VEL_W-3:0], b1, b2};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in[cidx_ff] = neg_ff ? (VEL_W'(0) - qv) : qv;
            if (cidx_ff == COMP_WZ) begin
               state_in = S_DONE;
            end else begin
               cidx_in  = cidx_ff + 1'b1;
               state_in = S_SUM;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {now_ff, res_ff[2], res_ff[1], res_ff[0]};
               rsp_user_in  = zero_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lin_gain_ff  <= LINEAR_GAIN_RST;
         ang_gain_ff  <= ANGULAR_GAIN_RST;
         tups_ff      <= TIME_UNITS_RST;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         mstep_ff     <= '0;
         dcnt_ff      <= '0;
         cidx_ff      <= COMP_VX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lin_gain_ff  <= lin_gain_in;
         ang_gain_ff  <= ang_gain_in;
         tups_ff      <= tups_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         mstep_ff     <= mstep_in;
         dcnt_ff      <= dcnt_in;
         cidx_ff      <= cidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      th_ff       <= th_in;
      ph_ff       <= ph_in;
      d_ff        <= d_in;
      dt_ff       <= dt_in;
      now_ff      <= now_in;
      zero_ff     <= zero_in;
      sum_ff      <= sum_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      p1_ff       <= p1_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

[rtl/mwo_checker.sv]
// Port checker for the mecanum wheel odometry top level, with its bind.
// Depends on mwo_pkg.
module mwo_checker
   import mwo_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_W-1:0]      rsp_tdata,
   input logic                  rsp_tuser
);

   a_rst_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word dropped or changed");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[3*VEL_W-1:0] == '0)
      else $error("zero interval word carries nonzero velocity");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result word appeared right after a sample word");

endmodule

bind mecanum_wheel_odometry_top mwo_checker u_mwo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
